/* src/iag_pkg.sv */
// Shared types, constants and helpers for the average-gradient block.
// No dependencies.
package iag_pkg;
	localparam int MaxWidthDef  = 2048;
	localparam int MaxHeightDef = 4096;
	localparam int FracBitsDef  = 8;
	localparam int WidthRegW    = 12;
	localparam int HeightRegW   = 13;
	localparam int CfgW         = 13;
	localparam int SumW         = 40;
	localparam int PixW         = 24;
	localparam int ResW         = 16;
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// Three-channel term job from front to back.
	typedef struct packed {
		logic [PixW-1:0] here;
		logic [PixW-1:0] below;
		logic [PixW-1:0] right;
		logic            acc;
		logic            fin;
	} iag_job_t;
endpackage

/* src/image_average_gradient.sv */
// Top level of the average-gradient sharpness block.
// Depends on iag_pkg, iag_front, iag_back.
//
// Usage: pixels enter on s_axis (tdata = blue, green, red from bit 0) in raster
// order; one result leaves on m_axis after the last pixel of each frame
// (tdata = grad_red, grad_green, grad_blue from bit 0, unsigned 8.8).
// Write frame_width (index 0) and frame_height (index 1) on the cfg port while
// idle. Each pixel passes through the front (line buffer read and job
// hand-off); each interior pixel then passes through the back's bit-serial
// square root, shared by the three channels in turn. The frame's end adds
// a serial divide for each channel. The front queues one job ahead, so it
// takes the next pixel while the back still works. Reset clears counters,
// neighbors, sums and restores width 2048, height 1024; the line buffer
// stays unwritten. When the receiver stalls, the result holds and the back
// stalls, then the front.
module image_average_gradient #(
	parameter int MAX_WIDTH  = iag_pkg::MaxWidthDef,
	parameter int MAX_HEIGHT = iag_pkg::MaxHeightDef,
	parameter int FRAC_BITS  = iag_pkg::FracBitsDef
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [23:0]              s_axis_tdata,  // pixel_blue, pixel_green, pixel_red
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [47:0]              m_axis_tdata,  // grad_red, grad_green, grad_blue
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [iag_pkg::CfgW-1:0] cfg_wdata
);
	import iag_pkg::*;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [WidthRegW-1:0]  width_q;
	logic [HeightRegW-1:0] height_q;
	logic [CW-1:0] w_m1;
	logic [RW-1:0] h_m1;
	logic job_valid, job_ready;
	iag_job_t job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthRegW'(2048);
			height_q <= HeightRegW'(1024);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_wdata[WidthRegW-1:0];
				CFG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// clamp dimensions, hand down last column / row index
	always_comb begin
		if (width_q < 2)                            w_m1 = CW'(1);
		else if (32'(width_q) > MAX_WIDTH)          w_m1 = CW'(MAX_WIDTH-1);
		else                                        w_m1 = CW'(width_q - 1'b1);
		if (height_q < 2)                           h_m1 = RW'(1);
		else if (32'(height_q) > MAX_HEIGHT)        h_m1 = RW'(MAX_HEIGHT-1);
		else                                        h_m1 = RW'(height_q - 1'b1);
	end

	iag_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.px(s_axis_tdata), .w_m1, .h_m1, .job_valid, .job_ready, .job
	);

	iag_back #(.FRAC_BITS(FRAC_BITS), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job, .w_m1, .h_m1,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(m_axis_tdata)
	);
endmodule

/* src/iag_front.sv */
// Front part: frame counters, line buffer and neighbor registers; builds jobs.
// Depends on iag_pkg.
module iag_front #(
	parameter int MAX_WIDTH  = iag_pkg::MaxWidthDef,
	parameter int MAX_HEIGHT = iag_pkg::MaxHeightDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [iag_pkg::PixW-1:0]     px,
	input  logic [$clog2(MAX_WIDTH)-1:0] w_m1,
	input  logic [$clog2(MAX_HEIGHT)-1:0] h_m1,
	output logic                         job_valid,
	input  logic                         job_ready,
	output iag_pkg::iag_job_t            job
);
	import iag_pkg::*;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [PixW-1:0] row_mem [MAX_WIDTH];
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [PixW-1:0] left_q, aleft_q, above_s1, px_s1;
	logic            v_s1, acc_s1, fin_s1;
	logic            st_s1;
	logic            take;

	// One item in flight at a time: read line buffer, then emit job.
	assign in_ready  = !v_s1 && !st_s1;
	assign take      = in_valid && in_ready;
	assign job_valid = st_s1;
	assign job.here  = aleft_q;
	assign job.below = left_q;
	assign job.right = above_s1;
	assign job.acc   = acc_s1;
	assign job.fin   = fin_s1;

	always_ff @(posedge clk) begin
		if (take) begin
			above_s1 <= row_mem[col_q];
			row_mem[col_q] <= px;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0; row_q <= '0; v_s1 <= 1'b0; st_s1 <= 1'b0;
			left_q <= '0; aleft_q <= '0; px_s1 <= '0;
			acc_s1 <= 1'b0; fin_s1 <= 1'b0;
		end else begin
			if (take) begin
				v_s1   <= 1'b1;
				px_s1  <= px;
				acc_s1 <= (col_q != '0) && (row_q != '0);
				fin_s1 <= (col_q >= w_m1) && (row_q >= h_m1);
				if (col_q >= w_m1) begin
					col_q <= '0;
					row_q <= (row_q >= h_m1) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (v_s1) begin
				v_s1  <= 1'b0;
				st_s1 <= 1'b1;
			end
			if (st_s1 && job_ready) begin
				// advance neighbor registers once the job has left
				st_s1   <= 1'b0;
				aleft_q <= above_s1;
				left_q  <= px_s1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(v_s1 && st_s1))
		else $error("two front stages busy");
	assert property (@(posedge clk) disable iff (!arst_n) take |=> v_s1)
		else $error("item lost in front");
	assert property (@(posedge clk) disable iff (!arst_n) (st_s1 && !job_ready) |=> st_s1)
		else $error("job dropped");
endmodule

/* src/iag_back.sv */
// Back part: serial square roots, sums, and serial divide for frame means.
// Depends on iag_pkg.
module iag_back #(
	parameter int FRAC_BITS = iag_pkg::FracBitsDef,
	parameter int MAX_WIDTH  = iag_pkg::MaxWidthDef,
	parameter int MAX_HEIGHT = iag_pkg::MaxHeightDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	output logic                          job_ready,
	input  iag_pkg::iag_job_t             job,
	input  logic [$clog2(MAX_WIDTH)-1:0]  w_m1,
	input  logic [$clog2(MAX_HEIGHT)-1:0] h_m1,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [3*iag_pkg::ResW-1:0]    res
);
	import iag_pkg::*;
	localparam int RAD  = 2*FRAC_BITS + 17;   // radicand bits
	localparam int RTW  = (RAD+1)/2;
	localparam int ITER = RTW;
	localparam int DVW  = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
	localparam int QW   = SumW;
	localparam int IW   = (QW > ITER ? $clog2(QW+1) : $clog2(ITER+1));

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001, S_SQRT = 5'b00010, S_ADD = 5'b00100,
		S_DIV = 5'b01000, S_OUT = 5'b10000
	} st_t;
	st_t st_q;

	logic [1:0]      ch_q;
	logic [IW-1:0]   it_q;
	logic [2*RTW-1:0] rem_q, rad_q;
	logic [RTW-1:0]  root_q;
	logic [SumW-1:0] sum_q [3];
	logic [PixW-1:0] here_q, below_q, right_q;
	logic            fin_q;
	logic [SumW-1:0] quo_q;
	logic [DVW:0]    drem_q;
	logic [DVW-1:0]  div_q;
	logic [ResW-1:0] out_q [3];

	logic [7:0]  ph, pb, pr;
	logic signed [17:0] dv, dh;
	logic [17:0] ss;
	logic [2*RTW-1:0] rad_n;
	logic [2*RTW-1:0] trial, rem_sh;
	logic [DVW:0] dsh;

	always_comb begin
		ph = here_q[8*ch_q +: 8];
		pb = below_q[8*ch_q +: 8];
		pr = right_q[8*ch_q +: 8];
		dv = $signed({10'b0, pb}) - $signed({10'b0, ph});
		dh = $signed({10'b0, pr}) - $signed({10'b0, ph});
		ss = 18'(dv*dv) + 18'(dh*dh);
		if (FRAC_BITS > 0) rad_n = (2*RTW)'(ss) << (2*FRAC_BITS-1);
		else               rad_n = (2*RTW)'(ss >> 1);
		rem_sh = {rem_q[2*RTW-3:0], rad_q[2*RTW-1 -: 2]};
		trial  = (2*RTW)'({root_q, 2'b01});
		dsh    = {drem_q[DVW-1:0], quo_q[QW-1]};
	end

	assign job_ready = (st_q == S_IDLE);
	assign res_valid = (st_q == S_OUT);
	assign res = {out_q[0], out_q[1], out_q[2]};

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			here_q <= job.here; below_q <= job.below; right_q <= job.right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; ch_q <= '0; it_q <= '0; fin_q <= 1'b0;
			for (int i = 0; i < 3; i++) sum_q[i] <= '0;
			rem_q <= '0; rad_q <= '0; root_q <= '0; quo_q <= '0; drem_q <= '0;
			div_q <= '0;
			for (int i = 0; i < 3; i++) out_q[i] <= '0;
		end else begin
			case (st_q)
				S_IDLE: if (job_valid) begin
					fin_q <= job.fin; ch_q <= '0;
					st_q  <= job.acc ? S_ADD : (job.fin ? S_DIV : S_IDLE);
					div_q <= DVW'(h_m1) * DVW'(w_m1);
					quo_q <= job.acc ? quo_q : sum_q[0];
					drem_q <= '0; it_q <= '0;
				end
				S_ADD: begin
					// load radicand for current channel
					rad_q <= rad_n; rem_q <= '0; root_q <= '0; it_q <= '0;
					st_q <= S_SQRT;
				end
				S_SQRT: begin
					if (rem_sh >= trial) begin
						rem_q  <= rem_sh - trial;
						root_q <= {root_q[RTW-2:0], 1'b1};
					end else begin
						rem_q  <= rem_sh;
						root_q <= {root_q[RTW-2:0], 1'b0};
					end
					rad_q <= rad_q << 2;
					if (it_q == IW'(ITER-1)) begin
						// finish a root: add it, go to next channel, divide or idle
						sum_q[ch_q] <= sum_q[ch_q] +
							SumW'({root_q[RTW-2:0], rem_sh >= trial});
						it_q <= '0;
						if (ch_q != 2'd2) begin
							ch_q <= ch_q + 1'b1; st_q <= S_ADD;
						end else if (fin_q) begin
							ch_q <= '0; st_q <= S_DIV; drem_q <= '0;
							quo_q <= sum_q[0];
						end else begin
							st_q <= S_IDLE;
						end
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				S_DIV: begin
					if (it_q == IW'(QW-1)) begin
						it_q <= '0; drem_q <= '0;
						out_q[ch_q] <= (quo_q[QW-2:0] >> (ResW-1)) != '0 ? '1 :
							ResW'({quo_q[QW-2:0], dsh >= {1'b0, div_q}});
						sum_q[ch_q] <= '0;
						if (ch_q == 2'd2) st_q <= S_OUT;
						else begin
							ch_q  <= ch_q + 1'b1;
							quo_q <= sum_q[ch_q + 1'b1];
						end
					end else begin
						if (dsh >= {1'b0, div_q}) drem_q <= dsh - {1'b0, div_q};
						else                      drem_q <= dsh;
						quo_q <= {quo_q[QW-2:0], dsh >= {1'b0, div_q}};
						it_q  <= it_q + 1'b1;
					end
				end
				S_OUT: if (res_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q))
		else $error("state not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n) ch_q != 2'd3)
		else $error("bad channel");
endmodule

/* verif/tb_image_average_gradient.sv */
// Self-checking testbench for image_average_gradient: streams pixel frames,
// predicts each frame's mean gradient and checks every result item.
// Depends on iag_pkg and image_average_gradient.
module tb_image_average_gradient;
	import iag_pkg::*;

	localparam int LineMax   = 2048;
	localparam int HeightMax = 4096;
	localparam int FracW     = 8;
	localparam int Settle    = 300;   // front + square root + serial divide, with margin
	localparam int StallMax  = 5000;  // cycles with no item moving before giving up

	typedef struct packed {
		logic [ResW-1:0] red;
		logic [ResW-1:0] green;
		logic [ResW-1:0] blue;
	} mean_grad_t;

	typedef enum int {PIX_RANDOM, PIX_SMOOTH, PIX_EXTREME} pix_style_e;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [23:0]         s_axis_tdata;   // pixel_blue, pixel_green, pixel_red
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [47:0]         m_axis_tdata;   // grad_red, grad_green, grad_blue
	logic                cfg_we;
	logic                cfg_index;
	logic [CfgW-1:0]     cfg_wdata;

	// Predictor copy of the block's registers and state.
	logic [WidthRegW-1:0]  width_reg;
	logic [HeightRegW-1:0] height_reg;
	logic [PixW-1:0]       line_mem [LineMax];
	logic [PixW-1:0]       left_px;
	logic [PixW-1:0]       above_left_px;
	int unsigned           col_pos;
	int unsigned           row_pos;
	longint unsigned       grad_sum [3];
	bit                    frame_closed;

	mean_grad_t  pending_means [$];
	int          err_count;
	int          pixels_sent;
	int          quiet_cycles;
	bit          steady;      // no idling on either side while set
	logic [23:0] prev_px;

	image_average_gradient DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Exact integer square root, bit by bit from the top pair.
	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// sqrt((dv^2 + dh^2) / 2) scaled by 2^FracW, truncated.
	function automatic longint unsigned channel_grad(logic [23:0] here, logic [23:0] below,
			logic [23:0] right, int ch);
		int dv;
		int dh;
		longint unsigned sq;
		dv = int'(below[8*ch +: 8]) - int'(here[8*ch +: 8]);
		dh = int'(right[8*ch +: 8]) - int'(here[8*ch +: 8]);
		sq = longint'(dv * dv + dh * dh);
		sq <<= (2 * FracW - 1);
		return root_floor(sq);
	endfunction

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v < 2)
			return 2;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Advance the predictor by one accepted pixel; queue a mean at the frame's end.
	task automatic advance_frame(logic [23:0] px);
		int unsigned w;
		int unsigned h;
		logic [23:0] above;
		longint unsigned area;
		longint unsigned q [3];
		mean_grad_t m;
		w = clamp_dim(width_reg, LineMax);
		h = clamp_dim(height_reg, HeightMax);
		above = line_mem[col_pos];
		if (col_pos >= 1 && row_pos >= 1) begin
			for (int c = 0; c < 3; c++)
				grad_sum[c] = (grad_sum[c] + channel_grad(above_left_px, left_px, above, c))
					& ((64'd1 << SumW) - 1);
		end
		above_left_px = above;
		left_px = px;
		line_mem[col_pos] = px;
		frame_closed = 1'b0;
		if (col_pos < w - 1) begin
			col_pos++;
		end else begin
			col_pos = 0;
			if (row_pos < h - 1) begin
				row_pos++;
			end else begin
				area = longint'(h - 1) * longint'(w - 1);
				for (int c = 0; c < 3; c++) begin
					q[c] = grad_sum[c] / area;
					if (q[c] > 64'hFFFF)
						q[c] = 64'hFFFF;
					grad_sum[c] = 0;
				end
				m.red = q[2][15:0];
				m.green = q[1][15:0];
				m.blue = q[0][15:0];
				pending_means.push_back(m);
				row_pos = 0;
				frame_closed = 1'b1;
			end
		end
	endtask

	// Send one pixel item, with a random gap ahead unless steady.
	task automatic send_pixel(logic [23:0] px);
		while (!steady && $urandom_range(99) < 29) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		do
			@(posedge clk);
		while (!s_axis_tready);
		advance_frame(px);
		pixels_sent++;
	endtask

	function automatic logic [23:0] make_pixel(pix_style_e style);
		logic [23:0] p;
		case (style)
			PIX_SMOOTH: begin
				for (int c = 0; c < 3; c++)
					p[8*c +: 8] = prev_px[8*c +: 8] + 8'($urandom_range(6)) - 8'd3;
			end
			PIX_EXTREME: begin
				for (int c = 0; c < 3; c++)
					p[8*c +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			default: begin
				p = 24'($urandom);
			end
		endcase
		prev_px = p;
		return p;
	endfunction

	// Send pixels until the predictor closes the frame.
	task automatic fill_frame(pix_style_e style);
		do
			send_pixel(make_pixel(style));
		while (!frame_closed);
	endtask

	// Drop valid, drain every expected mean and let the pipeline empty.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (Settle) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CfgW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_WIDTH)
			width_reg = val[WidthRegW-1:0];
		else
			height_reg = val;
	endtask

	task automatic set_frame(logic [CfgW-1:0] w, logic [CfgW-1:0] h);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
	endtask

	// Smallest frame: flat, full scale, steepest edge, one channel at a time.
	task automatic test_smallest_frame();
		set_frame(2, 2);
		for (int i = 0; i < 4; i++)
			send_pixel(24'h000000);
		for (int i = 0; i < 4; i++)
			send_pixel(24'hFFFFFF);
		send_pixel(24'h000000);
		send_pixel(24'hFFFFFF);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h000000);
		send_pixel(24'h0000FF);
		send_pixel(24'h00FF00);
		send_pixel(24'hFF0000);
		send_pixel(24'h808080);
		drain();
	endtask

	// Out-of-range register values clamp; width keeps only its low 12 bits.
	task automatic test_clamped_regs();
		set_frame(0, 1);
		fill_frame(PIX_EXTREME);
		drain();
		set_frame(13'h1003, 3);
		fill_frame(PIX_RANDOM);
		drain();
	endtask

	// Shrink a dimension mid-frame: the current row or frame ends early.
	task automatic test_mid_frame_shrink();
		set_frame(4, 5);
		for (int i = 0; i < 6; i++)
			send_pixel(make_pixel(PIX_RANDOM));
		drain();
		write_reg(CFG_HEIGHT, 2);
		fill_frame(PIX_RANDOM);
		drain();
		set_frame(6, 3);
		for (int i = 0; i < 9; i++)
			send_pixel(make_pixel(PIX_RANDOM));
		drain();
		write_reg(CFG_WIDTH, 3);
		fill_frame(PIX_RANDOM);
		drain();
	endtask

	// Many small frames of random size and content; the first stretch has no idling.
	task automatic test_random_frames();
		int start;
		pix_style_e style;
		start = pixels_sent;
		steady = 1'b1;
		while (pixels_sent - start < 770) begin
			if (pixels_sent - start > 200)
				steady = 1'b0;
			if ($urandom_range(9) == 0)
				set_frame(CfgW'($urandom_range(2, 40)), CfgW'($urandom_range(2, 12)));
			else
				set_frame(CfgW'($urandom_range(2, 8)), CfgW'($urandom_range(2, 6)));
			case ($urandom_range(2))
				0: style = PIX_SMOOTH;
				1: style = PIX_EXTREME;
				default: style = PIX_RANDOM;
			endcase
			fill_frame(style);
			drain();
		end
		steady = 1'b0;
	endtask

	// Widest and tallest register values, reached through the clamps; the row
	// must run on past the register's low bits, then narrow the frame to close it.
	task automatic test_largest_frames();
		steady = 1'b1;
		set_frame(4095, 8191);
		for (int i = 0; i < 40; i++)
			send_pixel(make_pixel(PIX_RANDOM));
		drain();
		set_frame(41, 2);
		fill_frame(PIX_SMOOTH);
		drain();
		steady = 1'b0;
	endtask

	// Receiver stalls at random, except during steady stretches.
	always @(posedge clk)
		m_axis_tready <= steady || ($urandom_range(99) >= 29);

	// Check each result item against the oldest expected mean.
	always @(posedge clk) begin
		mean_grad_t want;
		mean_grad_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.red = m_axis_tdata[15:0];
			got.green = m_axis_tdata[31:16];
			got.blue = m_axis_tdata[47:32];
			if (pending_means.size() == 0) begin
				$error("result item with nothing expected: %h", m_axis_tdata);
				err_count++;
			end else begin
				want = pending_means.pop_front();
				if (got.red !== want.red) begin
					$error("grad_red expected %0d got %0d", want.red, got.red);
					err_count++;
				end
				if (got.green !== want.green) begin
					$error("grad_green expected %0d got %0d", want.green, got.green);
					err_count++;
				end
				if (got.blue !== want.blue) begin
					$error("grad_blue expected %0d got %0d", want.blue, got.blue);
					err_count++;
				end
			end
		end
	end

	// Watchdog: count cycles in which no item moves on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallMax) begin
			$display("tb_image_average_gradient: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_wdata = '0;
		m_axis_tready = 1'b0;
		quiet_cycles = 0;
		err_count = 0;
		pixels_sent = 0;
		steady = 1'b0;
		prev_px = 24'h808080;
		width_reg = 12'd2048;
		height_reg = 13'd1024;
		left_px = '0;
		above_left_px = '0;
		col_pos = 0;
		row_pos = 0;
		frame_closed = 1'b0;
		for (int c = 0; c < 3; c++)
			grad_sum[c] = 0;
		for (int i = 0; i < LineMax; i++)
			line_mem[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_smallest_frame();
		test_clamped_regs();
		test_mid_frame_shrink();
		test_random_frames();
		test_largest_frames();

		drain();
		if (err_count == 0)
			$display("tb_image_average_gradient: clean");
		else
			$display("tb_image_average_gradient: errors");
		$finish;
	end
endmodule

/* files.f */
src/iag_pkg.sv
src/iag_front.sv
src/iag_back.sv
src/image_average_gradient.sv
verif/tb_image_average_gradient.sv
